FILE: hw/rtl/sm4_pkg.sv
// SM4 package: S-box, FK and CK constants, round functions.
// No dependencies.
`default_nettype none
package sm4_pkg;
	localparam int unsigned WordW = 32;
	localparam int unsigned BlockW = 64;

	typedef logic [WordW-1:0] word_t;
	typedef logic [7:0] byte_t;

	typedef enum logic {
		REG_KEY_HIGH = 1'b0,
		REG_KEY_LOW  = 1'b1
	} cfg_reg_t;

	localparam byte_t SBOX [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	localparam word_t FK0 = 32'hA3B1BAC6;
	localparam word_t FK1 = 32'h56AA3350;
	localparam word_t FK2 = 32'h677D9197;
	localparam word_t FK3 = 32'hB27022DC;

	function automatic word_t tau(input word_t x);
		return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
	endfunction

	function automatic word_t rotl(input word_t x, input int unsigned n);
		return (x << n) | (x >> (WordW - n));
	endfunction

	// CK byte j of round i = (4i+j)*7 mod 256
	function automatic word_t ck_word(input int unsigned i);
		word_t w;
		w = '0;
		for (int unsigned j = 0; j < 4; j++)
			w = {w[23:0], 8'(((4 * i + j) * 7) % 256)};
		return w;
	endfunction

	function automatic word_t key_round(input word_t k0, k1, k2, k3, ck);
		word_t t;
		t = tau(k1 ^ k2 ^ k3 ^ ck);
		return k0 ^ t ^ rotl(t, 13) ^ rotl(t, 23);
	endfunction

	function automatic word_t data_round(input word_t x0, x1, x2, x3, rk);
		word_t t;
		t = tau(x1 ^ x2 ^ x3 ^ rk);
		return x0 ^ t ^ rotl(t, 2) ^ rotl(t, 10) ^ rotl(t, 18) ^ rotl(t, 24);
	endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/sm4_if.sv
// Valid/ready channel interfaces for the SM4 block.
// Depends on sm4_pkg.
`default_nettype none
interface sm4_in_if import sm4_pkg::*; ();
	logic valid;
	logic ready;
	logic [BlockW-1:0] plain_high;
	logic [BlockW-1:0] plain_low;
	modport source (output valid, plain_high, plain_low, input ready);
	modport sink (input valid, plain_high, plain_low, output ready);
endinterface

interface sm4_out_if import sm4_pkg::*; ();
	logic valid;
	logic ready;
	logic [BlockW-1:0] cipher_high;
	logic [BlockW-1:0] cipher_low;
	modport source (output valid, cipher_high, cipher_low, input ready);
	modport sink (input valid, cipher_high, cipher_low, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/sm4_block_encrypt.sv
// SM4 encryption pipeline, top level.
// Depends on sm4_pkg and sm4_if.
//
// Use: write the key through cfg_we/cfg_index/cfg_data (index 0 key_high, 1 key_low)
// while the pipeline is empty. Plaintext transactions enter on in_ch, ciphertext
// leaves on out_ch, both valid/ready.
// Pipeline: one register stage per round, the first loaded at acceptance, then the
// output register that drives out_ch.valid.
// Throughput: one block per cycle unless stalled, set by the per-round stage, where
// the key round feeds its round key straight into the data round of the same stage.
// Stall: the whole pipeline holds when the output register is full and not
// taken; in_ch.ready is low only then. Nothing is lost or repeated.
// Reset: valid bits and the key clear to zero; payload registers are not reset.
`default_nettype none
module sm4_block_encrypt import sm4_pkg::*; #(
	parameter int unsigned ROUND_COUNT = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [BlockW-1:0] cfg_data,
	sm4_in_if.sink                 in_ch,
	sm4_out_if.source              out_ch
);
	logic [BlockW-1:0] key_high_q, key_low_q;
	word_t k_s [ROUND_COUNT+1][4];
	word_t x_s [ROUND_COUNT+1][4];
	logic  v_s [ROUND_COUNT+1];
	logic  adv;
	logic  out_valid_q;
	logic [BlockW-1:0] out_high_q, out_low_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_KEY_HIGH: key_high_q <= cfg_data;
				REG_KEY_LOW:  key_low_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv = !out_valid_q || out_ch.ready;
	assign in_ch.ready = adv;

	// stage 0 is combinational input
	always_comb begin
		v_s[0] = in_ch.valid;
		x_s[0][0] = in_ch.plain_high[63:32];
		x_s[0][1] = in_ch.plain_high[31:0];
		x_s[0][2] = in_ch.plain_low[63:32];
		x_s[0][3] = in_ch.plain_low[31:0];
		k_s[0][0] = key_high_q[63:32] ^ FK0;
		k_s[0][1] = key_high_q[31:0] ^ FK1;
		k_s[0][2] = key_low_q[63:32] ^ FK2;
		k_s[0][3] = key_low_q[31:0] ^ FK3;
	end

	for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
		word_t rk;
		assign rk = key_round(k_s[r][0], k_s[r][1], k_s[r][2], k_s[r][3], ck_word(r));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[r+1] <= 1'b0;
			else if (adv) v_s[r+1] <= v_s[r];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				k_s[r+1][0] <= k_s[r][1];
				k_s[r+1][1] <= k_s[r][2];
				k_s[r+1][2] <= k_s[r][3];
				k_s[r+1][3] <= rk;
				x_s[r+1][0] <= x_s[r][1];
				x_s[r+1][1] <= x_s[r][2];
				x_s[r+1][2] <= x_s[r][3];
				x_s[r+1][3] <= data_round(x_s[r][0], x_s[r][1], x_s[r][2], x_s[r][3], rk);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (adv) out_valid_q <= v_s[ROUND_COUNT];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_high_q <= {x_s[ROUND_COUNT][3], x_s[ROUND_COUNT][2]};
			out_low_q  <= {x_s[ROUND_COUNT][1], x_s[ROUND_COUNT][0]};
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.cipher_high = out_high_q;
	assign out_ch.cipher_low = out_low_q;
endmodule
`default_nettype wire

FILE: hw/rtl/sm4_block_encrypt_chk.sv
// Port-level checker for sm4_block_encrypt, bound to the top level.
// Depends on sm4_pkg.
`default_nettype none
module sm4_block_encrypt_chk import sm4_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [BlockW-1:0] cipher_high,
	input wire logic [BlockW-1:0] cipher_low
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cipher_high) && $stable(cipher_low))
		else $error("output changed under stall");
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready not tied to output stall");
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid straight after reset");
	a_hs_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({in_valid, in_ready, out_valid}))
		else $error("handshake signal unknown");
	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown({cipher_high, cipher_low}))
		else $error("ciphertext unknown while valid");
endmodule

bind sm4_block_encrypt sm4_block_encrypt_chk u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.cipher_high(out_ch.cipher_high), .cipher_low(out_ch.cipher_low)
);
`default_nettype wire

FILE: bench/tb_sm4_scoreboard.sv
`timescale 1ns / 1ps
// Scoreboard for the SM4 encryption block: own cipher model and expected queue.
// Depends on sm4_pkg for the key register names.
class sm4_cipher_scoreboard;
	typedef logic [63:0] half_t;
	static const logic [7:0] SUB [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	half_t key_hi, key_lo;
	half_t want_hi [$];
	half_t want_lo [$];
	int errors;
	int checked;

	function new();
		key_hi = '0;
		key_lo = '0;
		errors = 0;
		checked = 0;
	endfunction

	function void set_key(sm4_pkg::cfg_reg_t idx, half_t v);
		if (idx == sm4_pkg::REG_KEY_HIGH)
			key_hi = v;
		else
			key_lo = v;
	endfunction

	static function logic [31:0] subst(logic [31:0] w);
		return {SUB[w[31:24]], SUB[w[23:16]], SUB[w[15:8]], SUB[w[7:0]]};
	endfunction

	static function logic [31:0] rol(logic [31:0] w, int n);
		return (w << n) | (w >> (32 - n));
	endfunction

	function void note_plain(half_t p_hi, half_t p_lo);
		logic [31:0] k [4];
		logic [31:0] x [4];
		logic [31:0] t, rk, ck;
		logic [7:0] b;
		k[0] = key_hi[63:32] ^ 32'hA3B1BAC6;
		k[1] = key_hi[31:0] ^ 32'h56AA3350;
		k[2] = key_lo[63:32] ^ 32'h677D9197;
		k[3] = key_lo[31:0] ^ 32'hB27022DC;
		x[0] = p_hi[63:32];
		x[1] = p_hi[31:0];
		x[2] = p_lo[63:32];
		x[3] = p_lo[31:0];
		for (int r = 0; r < 32; r++) begin
			ck = '0;
			for (int j = 0; j < 4; j++) begin
				b = 8'((4 * r + j) * 7);
				ck = {ck[23:0], b};
			end
			t = subst(k[1] ^ k[2] ^ k[3] ^ ck);
			rk = k[0] ^ t ^ rol(t, 13) ^ rol(t, 23);
			k[0] = k[1]; k[1] = k[2]; k[2] = k[3]; k[3] = rk;
			t = subst(x[1] ^ x[2] ^ x[3] ^ rk);
			t = x[0] ^ t ^ rol(t, 2) ^ rol(t, 10) ^ rol(t, 18) ^ rol(t, 24);
			x[0] = x[1]; x[1] = x[2]; x[2] = x[3]; x[3] = t;
		end
		want_hi.push_back({x[3], x[2]});
		want_lo.push_back({x[1], x[0]});
	endfunction

	function void check_cipher(half_t c_hi, half_t c_lo);
		half_t e_hi, e_lo;
		if (want_hi.size() == 0) begin
			$display("%0t: unexpected ciphertext %h %h", $time, c_hi, c_lo);
			errors++;
			return;
		end
		e_hi = want_hi.pop_front();
		e_lo = want_lo.pop_front();
		checked++;
		if (c_hi !== e_hi) begin
			$display("%0t: cipher_high expected %h actual %h", $time, e_hi, c_hi);
			errors++;
		end
		if (c_lo !== e_lo) begin
			$display("%0t: cipher_low expected %h actual %h", $time, e_lo, c_lo);
			errors++;
		end
	endfunction

	function int pending();
		return want_hi.size();
	endfunction
endclass

FILE: bench/tb_sm4_block_encrypt.sv
`timescale 1ns / 1ps
// Top-level bench for sm4_block_encrypt: key writes, directed and random blocks,
// random stalls on both channels. Depends on sm4_pkg, sm4_if and tb_sm4_scoreboard.
module tb_sm4_block_encrypt;
	import sm4_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [BlockW-1:0] cfg_data = '0;
	logic hold_off = 1'b0;
	logic calm = 1'b0;
	int hold_len = 0;

	sm4_in_if in_ch ();
	sm4_out_if out_ch ();

	sm4_block_encrypt DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
	);

	sm4_cipher_scoreboard sb = new();
	int n_keys = 0;

	always #5 clk = ~clk;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.plain_high = '0;
		in_ch.plain_low = '0;
		out_ch.ready = 1'b0;
	end

	task automatic write_key(cfg_reg_t idx, logic [63:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		sb.set_key(idx, v);
		n_keys++;
	endtask

	task automatic set_keys(logic [63:0] hi, logic [63:0] lo);
		write_key(REG_KEY_HIGH, hi);
		write_key(REG_KEY_LOW, lo);
		cfg_we <= 1'b0;
	endtask

	task automatic send_block(logic [63:0] p_hi, logic [63:0] p_lo);
		while (!calm && $urandom_range(99) < 37) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.plain_high <= p_hi;
		in_ch.plain_low <= p_lo;
		do
			@(posedge clk);
		while (!in_ch.ready);
		sb.note_plain(p_hi, p_lo);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom(), $urandom()};
	endfunction

	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready)
			sb.check_cipher(out_ch.cipher_high, out_ch.cipher_low);
		if (hold_len > 0)
			hold_len <= hold_len - 1;
		out_ch.ready <= (hold_off || hold_len > 1) ? 1'b0
			: (calm ? 1'b1 : ($urandom_range(99) >= 37));
	end

	initial begin
		#2_000_000;
		$display("[sm4_block_encrypt] ERROR");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: reset key, then extremes of key and plaintext
		send_block('0, '0);
		send_block('1, '1);
		drain();
		set_keys(64'h0123456789abcdef, 64'hfedcba9876543210);
		send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
		send_block('0, '0);
		send_block('1, '1);
		send_block(64'h8000000000000000, 64'h0000000000000001);
		send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
		drain();
		set_keys('1, '1);
		send_block('0, '1);
		send_block('1, '0);
		send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
		drain();
		set_keys('0, 64'h0000000000000001);
		send_block(64'h0000000000000001, 64'h8000000000000000);
		send_block('1, '1);
		drain();
		// long receiver hold-off so the pipeline fills and blocks its input
		hold_off <= 1'b1;
		hold_len <= 0;
		for (int i = 0; i < 60; i++)
			send_block(rnd64(), rnd64());
		drain();
		// random phases, each under a fresh key
		for (int ph = 0; ph < 10; ph++) begin
			set_keys(rnd64(), rnd64());
			calm <= (ph == 4);
			for (int i = 0; i < 100; i++) begin
				if (ph == 7 && i == 50)
					hold_len <= 80;
				send_block(rnd64(), rnd64());
			end
			calm <= 1'b0;
			drain();
		end
		$display("covered %0d blocks under %0d key writes, with stalls on both sides",
			sb.checked, n_keys);
		$display("including a full pipeline under a long hold-off and one phase without idling");
		if (sb.errors == 0)
			$display("[sm4_block_encrypt] OK");
		else
			$display("[sm4_block_encrypt] ERROR");
		$finish;
	end

	// release the hold-off after a long stretch counted here
	initial begin
		@(posedge hold_off);
		repeat (200) @(posedge clk);
		hold_off <= 1'b0;
	end
endmodule

FILE: sim.f
hw/rtl/sm4_pkg.sv
hw/rtl/sm4_if.sv
hw/rtl/sm4_block_encrypt.sv
hw/rtl/sm4_block_encrypt_chk.sv
bench/tb_sm4_scoreboard.sv
bench/tb_sm4_block_encrypt.sv
